/* rtl/incremental_pi_speed_control_defines.svh */
// ============================================================================
// Assertion macros for the incremental PI speed control block
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ============================================================================
`ifndef INCREMENTAL_PI_SPEED_CONTROL_DEFINES_SVH
`define INCREMENTAL_PI_SPEED_CONTROL_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IPSC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IPSC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ipsc_pkg.sv */
// ============================================================================
// ipsc_pkg
// Widths, codes and item types shared by the PI speed control modules.
// ============================================================================
package ipsc_pkg;

    localparam int COUNT_W  = 11;
    localparam int TARGET_W = 16;
    localparam int GAIN_W   = 20;
    localparam int DUTY_W   = 10;
    localparam int ERR_W    = 19;
    localparam int DERR_W   = 20;
    localparam int PROD_P_W = GAIN_W + 1 + DERR_W;
    localparam int PROD_I_W = GAIN_W + 1 + ERR_W;
    localparam int SUM_W    = PROD_P_W + 1;
    localparam int DELTA_W  = 16;
    localparam int STEP_LIMIT = 100;
    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = 16;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    localparam logic [TARGET_W-1:0] TARGET_RESET   = 16'd6672;
    localparam logic [GAIN_W-1:0]   GAIN_P_RESET   = 20'd8192;
    localparam logic [GAIN_W-1:0]   GAIN_I_RESET   = 20'd82;

    typedef enum logic [1:0] {
        MODE_STOP = 2'd0,
        MODE_FWD  = 2'd1,
        MODE_BWD  = 2'd2,
        MODE_HOLD = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_TARGET = 2'd0,
        REG_GAIN_P = 2'd1,
        REG_GAIN_I = 2'd2,
        REG_MODE   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [TARGET_W-1:0] target;
        logic [GAIN_W-1:0]   gain_p;
        logic [GAIN_W-1:0]   gain_i;
        mode_t               mode;
    } cfg_t;

    typedef struct packed {
        logic                     stop;
        logic signed [ERR_W-1:0]  err;
        logic signed [DERR_W-1:0] derr;
    } err_item_t;

    typedef struct packed {
        logic                       stop;
        logic signed [PROD_P_W-1:0] prod_p;
        logic signed [PROD_I_W-1:0] prod_i;
    } prod_item_t;

    typedef struct packed {
        logic                      stop;
        logic signed [DELTA_W-1:0] delta;
    } delta_item_t;

endpackage

/* rtl/ipsc_err.sv */
// ============================================================================
// ipsc_err
// Input register stage: forms the speed error and its change per period.
// ============================================================================
`include "incremental_pi_speed_control_defines.svh"

module ipsc_err (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ipsc_pkg::cfg_t                  cfg,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [ipsc_pkg::COUNT_W-1:0]    count,
    output logic                            out_valid,
    input  logic                            out_ready,
    output ipsc_pkg::err_item_t             out_item
);
    import ipsc_pkg::*;

    logic                    valid_reg;
    logic                    valid_next;
    err_item_t               item_reg;
    err_item_t               item_next;
    logic signed [ERR_W-1:0] prev_err_reg;
    logic [COUNT_W-1:0]      mag;
    logic signed [ERR_W-1:0] err_meas;
    logic                    load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // A count of -1024 negates to 1024, which still fits as unsigned.
    assign mag      = count[COUNT_W-1] ? (~count + 1'b1) : count;
    assign err_meas = $signed(ERR_W'(cfg.target) - {mag, 8'd0});

    always_comb
    begin
        item_next.stop = 1'b0;
        item_next.err  = prev_err_reg;
        item_next.derr = '0;
        unique case (cfg.mode)
            MODE_STOP:
            begin
                item_next.stop = 1'b1;
                item_next.err  = '0;
            end
            MODE_FWD, MODE_BWD:
            begin
                item_next.err  = err_meas;
                item_next.derr = DERR_W'(err_meas) - DERR_W'(prev_err_reg);
            end
            MODE_HOLD:
            begin
                // The error is not refreshed; only the integral term acts.
                item_next.err = prev_err_reg;
            end
            default:
            begin
                item_next.err = prev_err_reg;
            end
        endcase
    end

    always_comb
    begin
        if (in_valid && in_ready)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            prev_err_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (load)
                prev_err_reg <= item_next.err;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    `IPSC_ASSERT_NXT(a_stop_clears_err, load && cfg.mode == MODE_STOP, prev_err_reg == '0, "stop did not clear the previous error")
    `IPSC_ASSERT_IMP(a_err_tracks_item, valid_reg && !item_reg.stop, item_reg.err == prev_err_reg || in_valid, "held error word disagrees with the error state")

endmodule

/* rtl/ipsc_step.sv */
// ============================================================================
// ipsc_step
// Gain products, then the clamped and floored step change in Q.8.
// ============================================================================
module ipsc_step #(
    parameter int GAIN_FRAC_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ipsc_pkg::cfg_t        cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ipsc_pkg::err_item_t   in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ipsc_pkg::delta_item_t out_item
);
    import ipsc_pkg::*;

    localparam logic signed [SUM_W-1:0] LIMIT =
        SUM_W'(STEP_LIMIT) <<< (8 + GAIN_FRAC_BITS);

    logic                    prod_valid_reg;
    logic                    prod_valid_next;
    prod_item_t              prod_reg;
    prod_item_t              prod_next;
    logic                    prod_ready;
    logic                    delta_valid_reg;
    logic                    delta_valid_next;
    delta_item_t             delta_reg;
    delta_item_t             delta_next;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] sum_clamped;

    assign in_ready   = !prod_valid_reg || prod_ready;
    assign prod_ready = !delta_valid_reg || out_ready;

    always_comb
    begin
        prod_next.stop   = in_item.stop;
        prod_next.prod_p = $signed({1'b0, cfg.gain_p}) * in_item.derr;
        prod_next.prod_i = $signed({1'b0, cfg.gain_i}) * in_item.err;
    end

    assign sum = SUM_W'(prod_reg.prod_p) + SUM_W'(prod_reg.prod_i);

    always_comb
    begin
        priority if (sum > LIMIT)
            sum_clamped = LIMIT;
        else if (sum < -LIMIT)
            sum_clamped = -LIMIT;
        else
            sum_clamped = sum;
    end

    // Taking the bits above the fraction of a two's complement word floors it.
    always_comb
    begin
        delta_next.stop  = prod_reg.stop;
        delta_next.delta = sum_clamped[GAIN_FRAC_BITS+DELTA_W-1:GAIN_FRAC_BITS];
    end

    always_comb
    begin
        if (in_valid && in_ready)
            prod_valid_next = 1'b1;
        else if (prod_ready)
            prod_valid_next = 1'b0;
        else
            prod_valid_next = prod_valid_reg;

        if (prod_valid_reg && prod_ready)
            delta_valid_next = 1'b1;
        else if (out_ready)
            delta_valid_next = 1'b0;
        else
            delta_valid_next = delta_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg  <= 1'b0;
            delta_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg  <= prod_valid_next;
            delta_valid_reg <= delta_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            prod_reg <= prod_next;
        if (prod_valid_reg && prod_ready)
            delta_reg <= delta_next;
    end

    assign out_valid = delta_valid_reg;
    assign out_item  = delta_reg;

endmodule

/* rtl/ipsc_accum.sv */
// ============================================================================
// ipsc_accum
// Duty accumulator with saturation and the registered duty output.
// ============================================================================
`include "incremental_pi_speed_control_defines.svh"

module ipsc_accum #(
    parameter int DUTY_MAX = 1023
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  ipsc_pkg::delta_item_t          in_item,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ipsc_pkg::DUTY_W-1:0]    duty
);
    import ipsc_pkg::*;

    localparam int ACC_W = $clog2(DUTY_MAX * 256 + 1);
    localparam logic signed [ACC_W+1:0] ACC_MAX = (ACC_W + 2)'(DUTY_MAX * 256);

    logic                    valid_reg;
    logic                    valid_next;
    logic [ACC_W-1:0]        acc_reg;
    logic [ACC_W-1:0]        acc_next;
    logic [DUTY_W-1:0]       duty_reg;
    logic [DUTY_W-1:0]       duty_next;
    logic signed [ACC_W+1:0] acc_sum;
    logic                    load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    assign acc_sum = $signed({2'b00, acc_reg}) + (ACC_W + 2)'(in_item.delta);

    always_comb
    begin
        priority if (in_item.stop)
            acc_next = '0;
        else if (acc_sum < 0)
            acc_next = '0;
        else if (acc_sum > ACC_MAX)
            acc_next = ACC_MAX[ACC_W-1:0];
        else
            acc_next = acc_sum[ACC_W-1:0];
    end

    assign duty_next = DUTY_W'(acc_next >> 8);

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            acc_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (load)
                acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            duty_reg <= duty_next;
    end

    assign out_valid = valid_reg;
    assign duty      = duty_reg;

    `IPSC_ASSERT_IMP(a_acc_in_range, 1'b1, {2'b00, acc_reg} <= ACC_MAX, "duty accumulator above its limit")
    `IPSC_ASSERT_IMP(a_duty_matches_acc, valid_reg, duty_reg == DUTY_W'(acc_reg >> 8), "duty word disagrees with the accumulator")
    `IPSC_ASSERT_NXT(a_stop_zero_duty, load && in_item.stop, acc_reg == '0 && duty_reg == '0, "stop word did not clear the duty")

endmodule

/* rtl/incremental_pi_speed_control.sv */
// A word accepted on s_axis passes the error, product, step and duty registers before its duty shows on m_axis.
// Throughput: one word per cycle while m_axis is ready; the error update and the
// accumulator add and clamp are each closed within a single stage.
// Back-pressure stalls only the stages that are full, so bubbles close up.
// Reset clears the error and duty state, empties the pipeline and restores the
// default target, gains and stop mode.
// ============================================================================
// incremental_pi_speed_control
// Velocity-form PI speed regulator: pulse count words in, PWM duty words out.
// ============================================================================
module incremental_pi_speed_control #(
    parameter int GAIN_FRAC_BITS = 12,
    parameter int DUTY_MAX       = 1023
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // tdata[10:0] pulse_count, tdata[15:11] zero
    input  logic [ipsc_pkg::TDATA_IN_W-1:0]      s_axis_tdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata[9:0] duty, tdata[15:10] zero
    output logic [ipsc_pkg::TDATA_OUT_W-1:0]     m_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ipsc_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [ipsc_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [ipsc_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);
    import ipsc_pkg::*;

    cfg_t        cfg_reg;
    reg_idx_t    reg_idx;
    logic        cfg_write;
    logic        err_valid;
    logic        err_ready;
    err_item_t   err_item;
    logic        delta_valid;
    logic        delta_ready;
    delta_item_t delta_item;
    logic [DUTY_W-1:0] duty;

    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target <= TARGET_RESET;
            cfg_reg.gain_p <= GAIN_P_RESET;
            cfg_reg.gain_i <= GAIN_I_RESET;
            cfg_reg.mode   <= MODE_STOP;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_TARGET: cfg_reg.target <= pwdata[TARGET_W-1:0];
                REG_GAIN_P: cfg_reg.gain_p <= pwdata[GAIN_W-1:0];
                REG_GAIN_I: cfg_reg.gain_i <= pwdata[GAIN_W-1:0];
                REG_MODE:   cfg_reg.mode   <= mode_t'(pwdata[1:0]);
                default:    cfg_reg.mode   <= cfg_reg.mode;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_TARGET: prdata = APB_DATA_W'(cfg_reg.target);
            REG_GAIN_P: prdata = APB_DATA_W'(cfg_reg.gain_p);
            REG_GAIN_I: prdata = APB_DATA_W'(cfg_reg.gain_i);
            REG_MODE:   prdata = APB_DATA_W'(cfg_reg.mode);
            default:    prdata = '0;
        endcase
    end

    ipsc_err u_err (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .count     (s_axis_tdata[COUNT_W-1:0]),
        .out_valid (err_valid),
        .out_ready (err_ready),
        .out_item  (err_item)
    );

    ipsc_step #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (err_valid),
        .in_ready  (err_ready),
        .in_item   (err_item),
        .out_valid (delta_valid),
        .out_ready (delta_ready),
        .out_item  (delta_item)
    );

    ipsc_accum #(
        .DUTY_MAX (DUTY_MAX)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (delta_valid),
        .in_ready  (delta_ready),
        .in_item   (delta_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .duty      (duty)
    );

    assign m_axis_tdata = TDATA_OUT_W'(duty);

endmodule

/* sim/tb_incremental_pi_speed_control.sv */
// ============================================================================
// tb_incremental_pi_speed_control
// Drives pulse count words into the PI speed regulator and checks every duty
// word against a cycle-free predictor of the velocity-form PI law. Register
// settings change between phases while the block is idle, and both stream
// sides idle at random, with one long output hold-off to back the block up.
// ============================================================================
module tb_incremental_pi_speed_control;

    import ipsc_pkg::*;

    localparam int     FRAC_BITS    = 12;
    localparam int     DUTY_LIMIT   = 1023;
    localparam longint STEP_CLAMP   = longint'(STEP_LIMIT) << (8 + FRAC_BITS);
    localparam int     SETTLE_CYCLES = 8;
    localparam int     HOLD_CYCLES  = 300;
    localparam int     CYCLE_LIMIT  = 800000;
    localparam int     RANDOM_PHASES = 12;
    localparam int     PHASE_ITEMS  = 110;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic [TDATA_IN_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [TDATA_OUT_W-1:0] m_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // Shadow copy of the registers and the regulator state.
    cfg_t   shadow_cfg = '{target: TARGET_RESET, gain_p: GAIN_P_RESET,
                           gain_i: GAIN_I_RESET, mode: MODE_STOP};
    int     err_prev = 0;
    longint duty_acc = 0;

    logic [COUNT_W-1:0] count_queue[$];
    logic [DUTY_W-1:0]  duty_expected[$];

    int   fail_count = 0;
    int   cycle_count = 0;
    int   send_gap = 0;
    int   rx_stall_left = 0;
    bit   tx_idle_on = 1'b0;
    bit   rx_idle_on = 1'b0;
    bit   pressure_go = 1'b0;
    logic rx_hold = 1'b0;

    incremental_pi_speed_control dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 clk = ~clk;

    // One regulator step for an accepted count; updates the shadow state.
    function automatic logic [DUTY_W-1:0] predict_duty(input logic signed [COUNT_W-1:0] count);
        int     c;
        int     magnitude;
        int     err;
        int     tgt;
        longint kp;
        longint ki;
        longint sum;
        longint delta;
        if (shadow_cfg.mode == MODE_STOP)
        begin
            err_prev = 0;
            duty_acc = 0;
            return '0;
        end
        c = count;
        tgt = shadow_cfg.target;
        kp = shadow_cfg.gain_p;
        ki = shadow_cfg.gain_i;
        if (shadow_cfg.mode == MODE_HOLD)
            err = err_prev;
        else
        begin
            magnitude = (c < 0) ? -c : c;
            err = tgt - magnitude * 256;
        end
        sum = kp * longint'(err - err_prev) + ki * longint'(err);
        if (sum > STEP_CLAMP)
            sum = STEP_CLAMP;
        if (sum < -STEP_CLAMP)
            sum = -STEP_CLAMP;
        // The offset keeps the shift on a non-negative value, so it floors.
        delta = ((sum + STEP_CLAMP) >> FRAC_BITS) - longint'(STEP_LIMIT) * 256;
        duty_acc = duty_acc + delta;
        if (duty_acc > longint'(DUTY_LIMIT) * 256)
            duty_acc = longint'(DUTY_LIMIT) * 256;
        if (duty_acc < 0)
            duty_acc = 0;
        err_prev = err;
        return DUTY_W'(duty_acc >> 8);
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap(input bit enabled);
        int r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count();
        int r;
        int nominal;
        int value;
        r = $urandom_range(0, 99);
        nominal = shadow_cfg.target >> 8;
        if (r < 45)
            value = nominal + int'($urandom_range(0, 12)) - 6;
        else if (r < 70)
            value = int'($urandom_range(0, 40)) - 20;
        else if (r < 92)
            return COUNT_W'($urandom_range(0, 2047));
        else
        begin
            case ($urandom_range(0, 3))
                0: value = -1024;
                1: value = 1023;
                2: value = 0;
                default: value = -1;
            endcase
            return COUNT_W'(value);
        end
        if ($urandom_range(0, 3) == 0)
            value = -value;
        return COUNT_W'(value);
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain(input int typical_max);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20)
            return '1;
        if (r < 70)
            return GAIN_W'($urandom_range(0, typical_max));
        return GAIN_W'($urandom_range(0, 1048575));
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    // Register write; the callers fill the bits above the register's width with random junk.
    task automatic apb_write(input reg_idx_t idx, input logic [APB_DATA_W-1:0] word);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_TARGET: shadow_cfg.target = word[TARGET_W-1:0];
            REG_GAIN_P: shadow_cfg.gain_p = word[GAIN_W-1:0];
            REG_GAIN_I: shadow_cfg.gain_i = word[GAIN_W-1:0];
            REG_MODE:   shadow_cfg.mode = mode_t'(word[1:0]);
        endcase
    endtask

    task automatic write_target(input logic [TARGET_W-1:0] value);
        logic [APB_DATA_W-1:0] word;
        word = $urandom();
        word[TARGET_W-1:0] = value;
        apb_write(REG_TARGET, word);
    endtask

    task automatic write_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki);
        logic [APB_DATA_W-1:0] word;
        word = $urandom();
        word[GAIN_W-1:0] = kp;
        apb_write(REG_GAIN_P, word);
        word = $urandom();
        word[GAIN_W-1:0] = ki;
        apb_write(REG_GAIN_I, word);
    endtask

    task automatic write_mode(input mode_t mode);
        logic [APB_DATA_W-1:0] word;
        word = $urandom();
        word[1:0] = mode;
        apb_write(REG_MODE, word);
    endtask

    task automatic push_counts(input int values[]);
        foreach (values[i])
            count_queue.push_back(COUNT_W'(values[i]));
    endtask

    // Waits until every word has gone in and every duty word has come back.
    // The check runs on the falling edge so the driver's updates have settled.
    task automatic drain();
        while (count_queue.size() != 0 || s_axis_tvalid || duty_expected.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Input side: predicts at each accepted word, then offers the next one.
    always @(posedge clk)
    begin : feed_counts
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                duty_expected.push_back(predict_duty(s_axis_tdata[COUNT_W-1:0]));
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (count_queue.size() != 0)
                begin
                    s_axis_tdata <= {{(TDATA_IN_W - COUNT_W){1'b0}}, count_queue.pop_front()};
                    s_axis_tvalid <= 1'b1;
                    send_gap = pick_gap(tx_idle_on);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output side: checks each accepted duty word and throttles tready.
    always @(posedge clk)
    begin : check_duty
        logic [DUTY_W-1:0] want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (duty_expected.size() == 0)
                    report_mismatch("unexpected duty word", m_axis_tdata, -1);
                else
                begin
                    want = duty_expected.pop_front();
                    if (m_axis_tdata[DUTY_W-1:0] !== want)
                        report_mismatch("duty", m_axis_tdata[DUTY_W-1:0], want);
                    if (m_axis_tdata[TDATA_OUT_W-1:DUTY_W] !== '0)
                        report_mismatch("duty padding", m_axis_tdata[TDATA_OUT_W-1:DUTY_W], 0);
                end
            end
            if (rx_hold)
                m_axis_tready <= 1'b0;
            else if (rx_stall_left > 0)
            begin
                rx_stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                rx_stall_left = pick_gap(rx_idle_on);
            end
        end
    end

    // Long output hold-off so the pipeline fills and the input stalls.
    initial
    begin : output_hold_off
        wait (pressure_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** incremental_pi_speed_control: FAILED **");
            $finish;
        end
    end

    initial
    begin : stimulus
        int r;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: stop mode forces a zero duty, even for the most
        // negative count.
        push_counts('{7, -1024});
        drain();

        // Default gains, forward: ramp up, then the count extremes.
        write_mode(MODE_FWD);
        push_counts('{0, 0, 0, 26, -26, 1023, -1024, -1, 1, 0, 0});
        drain();

        // Largest target and gains in backward mode: steps clamp both ways.
        write_target('1);
        write_gains('1, '1);
        write_mode(MODE_BWD);
        push_counts('{0, -1024, 0, 0});
        drain();

        // Hold mode keeps the last error, so the duty climbs to its top.
        write_mode(MODE_HOLD);
        push_counts('{5, -5, 1023, -1024, 0, 0, 3, 100, 0});
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            r = $urandom_range(0, 99);
            case ($urandom_range(0, 3))
                0: write_target(($urandom_range(0, 1) != 0) ? '1 : '0);
                default: write_target(TARGET_W'($urandom_range(0, 65535)));
            endcase
            write_gains(pick_gain(16384), pick_gain(4096));
            if (r < 10)
                write_mode(MODE_STOP);
            else if (r < 25)
                write_mode(MODE_HOLD);
            else if (r < 62)
                write_mode(MODE_FWD);
            else
                write_mode(MODE_BWD);
            tx_idle_on = (phase != 0) && ($urandom_range(0, 3) != 0);
            rx_idle_on = (phase != 0) && ($urandom_range(0, 3) != 0);
            if (phase == 2)
                pressure_go = 1'b1;
            repeat (PHASE_ITEMS)
                count_queue.push_back(pick_count());
            drain();
        end

        if (fail_count == 0)
            $display("** incremental_pi_speed_control: PASSED **");
        else
            $display("** incremental_pi_speed_control: FAILED **");
        $finish;
    end

endmodule
